// File: hdl/ksc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksc_pkg
// Types and constants shared by the Kermit sender control block.
// ----------------------------------------------------------------------------
package ksc_pkg;

	localparam int SEQ_MODULUS = 64;
	localparam int FULL_CHUNK  = 254;

	localparam logic [5:0] SEQ_MAX        = 6'(SEQ_MODULUS - 1);
	localparam logic [7:0] FULL_CHUNK_LEN = 8'(FULL_CHUNK);

	// configuration register indexes
	localparam logic [1:0] REG_FILE_COUNT   = 2'd0;
	localparam logic [1:0] REG_INIT_RETRIES = 2'd1;
	localparam logic [1:0] REG_RETRY_LIMIT  = 2'd2;

	localparam logic [7:0] FILE_COUNT_RST   = 8'd1;
	localparam logic [2:0] INIT_RETRIES_RST = 3'd2;
	localparam logic [2:0] RETRY_LIMIT_RST  = 3'd3;

	typedef enum logic [1:0] {
		FUNC_START   = 2'd0,
		FUNC_REPLY   = 2'd1,
		FUNC_TIMEOUT = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_S       = 3'd1,
		ACT_F       = 3'd2,
		ACT_D       = 3'd3,
		ACT_Z       = 3'd4,
		ACT_B       = 3'd5,
		ACT_RESEND  = 3'd6,
		ACT_RESTAMP = 3'd7
	} action_t;

	typedef struct packed {
		func_t      func;
		logic       reply_is_nak;
		logic [5:0] reply_seq;
		logic [7:0] chunk_len;
	} event_t;

	typedef struct packed {
		logic [7:0] file_count;
		logic [2:0] init_retries;
		logic [2:0] retry_limit;
	} cfg_t;

	typedef struct packed {
		action_t    action;
		logic [5:0] packet_seq;
		logic [7:0] file_index;
		logic [7:0] data_len;
		logic       done_res;
		logic       aborted;
	} result_t;

endpackage

// File: hdl/ksc_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksc_fsm
// Transfer phase, sequence, retry budget and file count; one event per step,
// result registered on the same edge the state moves.
// ----------------------------------------------------------------------------
module ksc_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ksc_pkg::event_t  evt,
	input  ksc_pkg::cfg_t    cfg,
	output ksc_pkg::result_t res
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_INIT  = 3'd1,
		PH_FILE  = 3'd2,
		PH_DATA  = 3'd3,
		PH_EOF   = 3'd4,
		PH_EOT   = 3'd5,
		PH_STOP  = 3'd6,
		PH_ABORT = 3'd7
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [5:0]       seq_q, seq_d;
	logic [2:0]       retries_q, retries_d;
	logic [7:0]       files_q, files_d;
	ksc_pkg::result_t res_q, res_d;

	logic             timeout;
	logic             stale;
	logic [7:0]       clen;

	// a zero budget register counts as one
	function automatic logic [2:0] budget(input logic [2:0] r);
		return (r == 3'd0) ? 3'd1 : r;
	endfunction

	assign timeout = (evt.func == ksc_pkg::FUNC_TIMEOUT);
	assign stale   = (evt.func == ksc_pkg::FUNC_REPLY) && (evt.reply_seq < seq_q);
	assign clen    = (evt.chunk_len > ksc_pkg::FULL_CHUNK_LEN) ?
	                 ksc_pkg::FULL_CHUNK_LEN : evt.chunk_len;

	always_comb begin
		phase_d          = phase_q;
		seq_d            = seq_q;
		retries_d        = retries_q;
		files_d          = files_q;
		res_d            = '0;
		res_d.action     = ksc_pkg::ACT_NONE;

		case (evt.func)
			ksc_pkg::FUNC_START: begin
				if (phase_q == PH_IDLE) begin
					seq_d        = '0;
					retries_d    = budget(cfg.init_retries);
					phase_d      = PH_INIT;
					res_d.action = ksc_pkg::ACT_S;
				end
			end
			ksc_pkg::FUNC_REPLY, ksc_pkg::FUNC_TIMEOUT: begin
				if (phase_q inside {[PH_INIT:PH_EOT]}) begin
					if (timeout || stale) begin
						// stale reply is free, except while waiting on S
						if (timeout || phase_q == PH_INIT)
							retries_d = retries_q - 3'd1;
						res_d.action = ksc_pkg::ACT_RESEND;
						if (retries_d == 3'd0)
							phase_d = PH_ABORT;
					end else begin
						seq_d     = (seq_q == ksc_pkg::SEQ_MAX) ? 6'd0 : seq_q + 6'd1;
						retries_d = budget(cfg.retry_limit);
						if (evt.reply_is_nak) begin
							res_d.action = ksc_pkg::ACT_RESTAMP;
						end else begin
							case (phase_q)
								PH_INIT: begin
									res_d.action     = ksc_pkg::ACT_F;
									res_d.file_index = 8'd1;
									files_d          = 8'd1;
									phase_d          = PH_DATA;
								end
								PH_FILE: begin
									if (files_q < cfg.file_count) begin
										files_d          = files_q + 8'd1;
										res_d.action     = ksc_pkg::ACT_F;
										res_d.file_index = files_d;
										phase_d          = PH_DATA;
									end else begin
										res_d.action = ksc_pkg::ACT_B;
										phase_d      = PH_EOT;
									end
								end
								PH_DATA: begin
									// short chunk closes the file
									if (clen < ksc_pkg::FULL_CHUNK_LEN)
										phase_d = PH_EOF;
									res_d.action   = ksc_pkg::ACT_D;
									res_d.data_len = clen + 8'd1;
								end
								PH_EOF: begin
									res_d.action = ksc_pkg::ACT_Z;
									phase_d = (files_q < cfg.file_count) ? PH_FILE : PH_EOT;
								end
								default: begin
									res_d.action = ksc_pkg::ACT_B;
									phase_d      = PH_STOP;
								end
							endcase
						end
					end
				end
			end
			default: ;
		endcase

		res_d.packet_seq = (res_d.action == ksc_pkg::ACT_NONE) ? 6'd0 : seq_d;
		res_d.done_res   = (phase_d == PH_STOP);
		res_d.aborted    = (phase_d == PH_ABORT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			seq_q     <= '0;
			retries_q <= ksc_pkg::INIT_RETRIES_RST;
			files_q   <= '0;
			res_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			seq_q     <= seq_d;
			retries_q <= retries_d;
			files_q   <= files_d;
			res_q     <= res_d;
		end
	end

	assign res = res_q;

endmodule

// File: hdl/kermit_sender_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kermit_sender_control
// Sender-side control of a Kermit-style transfer: events in, next packet out.
//
//   channel  dir  handshake              payload
//   s_axis   in   tvalid/tready          tuser: func, reply_is_nak
//                                        tdata: reply_seq, chunk_len
//   m_axis   out  tvalid/tready          tuser: action
//                                        tdata: packet_seq .. aborted
//   cfg      in   cfg_we                 cfg_index, cfg_wdata
//
// One word per cycle sustained while m_axis is not stalled; a word passes the
// input register, then the state update that loads the result register.
// arst_n returns phase to idle and the config registers to their defaults.
// A stalled m_axis holds its word; the input register keeps taking words as
// long as the result register drains.
// ----------------------------------------------------------------------------
module kermit_sender_control (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // reply_seq[5:0], chunk_len[13:6], zero pad
	input  logic [2:0]  s_axis_tuser,  // func[1:0], reply_is_nak[2]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // packet_seq[5:0], file_index[13:6],
	                                   // data_len[21:14], done_res[22], aborted[23]
	output logic [2:0]  m_axis_tuser,  // action[2:0]

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	ksc_pkg::cfg_t    cfg_q;
	ksc_pkg::event_t  evt_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic             step;
	ksc_pkg::result_t res;

	assign step          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_count   <= ksc_pkg::FILE_COUNT_RST;
			cfg_q.init_retries <= ksc_pkg::INIT_RETRIES_RST;
			cfg_q.retry_limit  <= ksc_pkg::RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ksc_pkg::REG_FILE_COUNT:   cfg_q.file_count   <= cfg_wdata;
				ksc_pkg::REG_INIT_RETRIES: cfg_q.init_retries <= cfg_wdata[2:0];
				ksc_pkg::REG_RETRY_LIMIT:  cfg_q.retry_limit  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (step)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			evt_s1.func         <= ksc_pkg::func_t'(s_axis_tuser[1:0]);
			evt_s1.reply_is_nak <= s_axis_tuser[2];
			evt_s1.reply_seq    <= s_axis_tdata[5:0];
			evt_s1.chunk_len    <= s_axis_tdata[13:6];
		end
	end

	ksc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.evt    (evt_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res.action;
	assign m_axis_tdata  = {res.aborted, res.done_res, res.data_len,
	                        res.file_index, res.packet_seq};

endmodule

// File: hdl/ksc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksc_checker
// Port-level checks on the sender control result stream.
// ----------------------------------------------------------------------------
module ksc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	// a stalled word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("ksc: output word changed while stalled");

	// no packet means no sequence number
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ksc_pkg::ACT_NONE |-> m_axis_tdata[5:0] == 6'd0)
		else $error("ksc: sequence on an empty action");

	// file index only on F, and never zero there
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tuser == ksc_pkg::ACT_F) == (m_axis_tdata[13:6] != 8'd0)))
		else $error("ksc: file index does not match action");

	// data length only on D, and never zero there
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tuser == ksc_pkg::ACT_D) == (m_axis_tdata[21:14] != 8'd0)))
		else $error("ksc: data length does not match action");

	// finished and aborted exclude each other
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[22] && m_axis_tdata[23]))
		else $error("ksc: done and aborted both set");

endmodule

bind kermit_sender_control ksc_checker u_ksc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: verif/tb_kermit_sender_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kermit_sender_control
// Self-checking bench for the Kermit sender control block. The stimulus
// thread walks one transfer session: idle events, the S handshake, many
// files of D chunks with NAKs, stale replies and timeouts mixed in, then a
// random finish (clean end of transfer, no file left for F, or an abort).
// A predictor in the bench tracks phase, sequence and retries and plans the
// expected packet for every event word. Bursty sender, stalling receiver.
// ----------------------------------------------------------------------------
module tb_kermit_sender_control;

	localparam logic [1:0] REG_UNUSED   = 2'd3;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;
	localparam int DUT_LATENCY      = 2;
	localparam int RANDOM_PHASES    = 6;
	localparam int PHASE_WORDS      = 120;
	localparam int LONG_HOLD        = 400;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int MAX_ERROR_LINES  = 40;

	typedef enum logic [2:0] {
		PH_IDLE, PH_INIT, PH_FILE, PH_DATA, PH_EOF, PH_EOT, PH_STOP, PH_ABORT
	} phase_t;

	typedef struct packed {
		ksc_pkg::event_t  ev;
		ksc_pkg::result_t res;
	} planned_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // reply_seq[5:0], chunk_len[13:6], zero pad
	logic [2:0]  s_axis_tuser = '0;   // func[1:0], reply_is_nak[2]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // packet_seq, file_index, data_len, done_res, aborted
	logic [2:0]  m_axis_tuser;        // action[2:0]
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;

	kermit_sender_control dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// session predictor state and register shadow
	phase_t     ph;
	logic [5:0] seq_no;
	logic [2:0] retries_left;
	logic [7:0] files_sent;
	logic [7:0] cfg_files;
	logic [2:0] cfg_init;
	logic [2:0] cfg_limit;

	planned_t         outbound_events[$];
	ksc_pkg::result_t due_packets[$];

	int events_sent = 0;
	int packets_checked = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int actions_planned[8];
	string how_ended = "unfinished";

	function automatic logic [2:0] budget_of(input logic [2:0] r);
		return (r == 3'd0) ? 3'd1 : r;
	endfunction

	function automatic ksc_pkg::result_t next_packet(input ksc_pkg::event_t ev);
		ksc_pkg::result_t r;
		logic [7:0] clen;
		r = '0;
		clen = ev.chunk_len;
		if (ev.func == ksc_pkg::FUNC_START) begin
			if (ph == PH_IDLE) begin
				seq_no = 6'd0;
				retries_left = budget_of(cfg_init);
				ph = PH_INIT;
				r.action = ksc_pkg::ACT_S;
			end
		end else if ((ev.func == ksc_pkg::FUNC_REPLY || ev.func == ksc_pkg::FUNC_TIMEOUT) &&
		             ph >= PH_INIT && ph <= PH_EOT) begin
			if (ev.func == ksc_pkg::FUNC_TIMEOUT || ev.reply_seq < seq_no) begin
				// stale replies cost a retry only while waiting on S
				if (ev.func == ksc_pkg::FUNC_TIMEOUT || ph == PH_INIT)
					retries_left = retries_left - 3'd1;
				r.action = ksc_pkg::ACT_RESEND;
				if (retries_left == 3'd0)
					ph = PH_ABORT;
			end else begin
				seq_no = 6'((seq_no + 1) % ksc_pkg::SEQ_MODULUS);
				retries_left = budget_of(cfg_limit);
				if (ev.reply_is_nak) begin
					r.action = ksc_pkg::ACT_RESTAMP;
				end else begin
					case (ph)
						PH_INIT: begin
							r.action = ksc_pkg::ACT_F;
							files_sent = 8'd1;
							r.file_index = 8'd1;
							ph = PH_DATA;
						end
						PH_FILE: begin
							if (files_sent < cfg_files) begin
								files_sent = files_sent + 8'd1;
								r.action = ksc_pkg::ACT_F;
								r.file_index = files_sent;
								ph = PH_DATA;
							end else begin
								r.action = ksc_pkg::ACT_B;
								ph = PH_EOT;
							end
						end
						PH_DATA: begin
							if (clen > ksc_pkg::FULL_CHUNK_LEN)
								clen = ksc_pkg::FULL_CHUNK_LEN;
							if (clen < ksc_pkg::FULL_CHUNK_LEN)
								ph = PH_EOF;
							r.action = ksc_pkg::ACT_D;
							r.data_len = clen + 8'd1;
						end
						PH_EOF: begin
							r.action = ksc_pkg::ACT_Z;
							ph = (files_sent < cfg_files) ? PH_FILE : PH_EOT;
						end
						default: begin
							r.action = ksc_pkg::ACT_B;
							ph = PH_STOP;
						end
					endcase
				end
			end
		end
		r.packet_seq = (r.action == ksc_pkg::ACT_NONE) ? 6'd0 : seq_no;
		r.done_res = (ph == PH_STOP);
		r.aborted = (ph == PH_ABORT);
		return r;
	endfunction

	function automatic ksc_pkg::event_t mk(input ksc_pkg::func_t f, input logic nak,
	                                       input logic [5:0] rs, input logic [7:0] cl);
		ksc_pkg::event_t ev;
		ev.func = f;
		ev.reply_is_nak = nak;
		ev.reply_seq = rs;
		ev.chunk_len = cl;
		return ev;
	endfunction

	// reply carrying a sequence at or above the current one
	function automatic ksc_pkg::event_t valid_reply(input logic nak, input logic [7:0] cl);
		return mk(ksc_pkg::FUNC_REPLY, nak, 6'($urandom_range(ksc_pkg::SEQ_MAX, seq_no)), cl);
	endfunction

	task automatic queue_word(input ksc_pkg::event_t ev);
		planned_t p;
		p.ev = ev;
		p.res = next_packet(ev);
		outbound_events.push_back(p);
		actions_planned[p.res.action]++;
	endtask

	task automatic queue_random_step(output bit counted);
		ksc_pkg::event_t ev;
		int unsigned pick;
		ev = mk(ksc_pkg::FUNC_REPLY, $urandom_range(0, 9) == 0, 6'($urandom), 8'($urandom));
		pick = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 4) begin
			ev.func = (pick < 2) ? ksc_pkg::FUNC_START : ksc_pkg::func_t'(FUNC_UNUSED);
			counted = 1'b0;
		end else if (pick < 12 && seq_no != 6'd0) begin
			ev.reply_seq = 6'($urandom_range(0, int'(seq_no) - 1));
		end else if (pick < 20 && retries_left > 3'd1) begin
			ev.func = ksc_pkg::FUNC_TIMEOUT;
		end else begin
			ev.reply_seq = 6'($urandom_range(ksc_pkg::SEQ_MAX, seq_no));
			if (ph == PH_DATA) begin
				pick = $urandom_range(0, 19);
				if (pick < 12)
					ev.chunk_len = ksc_pkg::FULL_CHUNK_LEN;
				else if (pick == 12)
					ev.chunk_len = 8'hFF;
				else
					ev.chunk_len = 8'($urandom_range(0, ksc_pkg::FULL_CHUNK - 1));
			end
		end
		queue_word(ev);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ksc_pkg::REG_FILE_COUNT:   cfg_files = val;
			ksc_pkg::REG_INIT_RETRIES: cfg_init = val[2:0];
			ksc_pkg::REG_RETRY_LIMIT:  cfg_limit = val[2:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (outbound_events.size() != 0 || s_axis_tvalid || due_packets.size() != 0);
		repeat (DUT_LATENCY) @(negedge clk);
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got_v,
	                               input logic [31:0] want_v);
		mismatches++;
		if (mismatches <= MAX_ERROR_LINES)
			$display("ERROR packet %0d: %s got 0x%0h, want 0x%0h",
			         packets_checked, field, got_v, want_v);
	endtask

	// sender: bursts of words with random gaps
	int burst_left = 16;
	int gap_left = 0;

	always @(posedge clk) begin : sender
		planned_t step;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				step = outbound_events.pop_front();
				due_packets.push_back(step.res);
				events_sent++;
				if (burst_left != 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (outbound_events.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {2'b00, outbound_events[0].ev.chunk_len,
					                 outbound_events[0].ev.reply_seq};
					s_axis_tuser <= {outbound_events[0].ev.reply_is_nak,
					                 outbound_events[0].ev.func};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches between random modes; one long hold
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	int mode_left = 0;
	int ready_mode = 0;

	always @(posedge clk) begin : receiver
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!long_hold_done && packets_checked >= 200 &&
		             outbound_events.size() > 8) begin
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(16, 80);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		ksc_pkg::result_t want;
		ksc_pkg::result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.action = ksc_pkg::action_t'(m_axis_tuser);
			got.packet_seq = m_axis_tdata[5:0];
			got.file_index = m_axis_tdata[13:6];
			got.data_len = m_axis_tdata[21:14];
			got.done_res = m_axis_tdata[22];
			got.aborted = m_axis_tdata[23];
			if (due_packets.size() == 0) begin
				report_mismatch("word with nothing due, action", got.action, 0);
			end else begin
				want = due_packets.pop_front();
				if (got.action != want.action)
					report_mismatch("action", got.action, want.action);
				if (got.packet_seq != want.packet_seq)
					report_mismatch("packet_seq", got.packet_seq, want.packet_seq);
				if (got.file_index != want.file_index)
					report_mismatch("file_index", got.file_index, want.file_index);
				if (got.data_len != want.data_len)
					report_mismatch("data_len", got.data_len, want.data_len);
				if (got.done_res !== want.done_res)
					report_mismatch("done_res", got.done_res, want.done_res);
				if (got.aborted !== want.aborted)
					report_mismatch("aborted", got.aborted, want.aborted);
			end
			packets_checked++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		int n;
		bit c;
		int unsigned pick;

		ph = PH_IDLE;
		seq_no = 6'd0;
		files_sent = 8'd0;
		cfg_files = ksc_pkg::FILE_COUNT_RST;
		cfg_init = ksc_pkg::INIT_RETRIES_RST;
		cfg_limit = ksc_pkg::RETRY_LIMIT_RST;
		retries_left = cfg_init;
		foreach (actions_planned[i])
			actions_planned[i] = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// events before start are ignored
		queue_word(mk(ksc_pkg::FUNC_REPLY, 1'b0, ksc_pkg::SEQ_MAX, ksc_pkg::FULL_CHUNK_LEN));
		queue_word(mk(ksc_pkg::FUNC_TIMEOUT, 1'b1, 6'd0, 8'd0));
		queue_word(mk(ksc_pkg::func_t'(FUNC_UNUSED), 1'b1, ksc_pkg::SEQ_MAX, 8'hFF));
		wait_drained();
		write_reg(ksc_pkg::REG_FILE_COUNT, 8'd1);
		write_reg(ksc_pkg::REG_INIT_RETRIES, {5'($urandom), 3'd7});
		write_reg(ksc_pkg::REG_RETRY_LIMIT, {5'($urandom), 3'd7});
		write_reg(REG_UNUSED, 8'($urandom));

		// S handshake: retries, restamp, stale reply while waiting on S
		queue_word(mk(ksc_pkg::FUNC_START, 1'b0, 6'd0, 8'd0));
		queue_word(mk(ksc_pkg::FUNC_START, 1'b1, ksc_pkg::SEQ_MAX, 8'hFF));
		queue_word(mk(ksc_pkg::FUNC_TIMEOUT, 1'b0, 6'd0, 8'd0));
		queue_word(mk(ksc_pkg::FUNC_TIMEOUT, 1'b1, ksc_pkg::SEQ_MAX, 8'hFF));
		queue_word(mk(ksc_pkg::FUNC_REPLY, 1'b1, 6'd0, 8'd0));
		queue_word(mk(ksc_pkg::FUNC_REPLY, 1'b0, 6'd0, 8'd0));
		queue_word(mk(ksc_pkg::FUNC_REPLY, 1'b0, ksc_pkg::SEQ_MAX, 8'd0));
		// first file: full, oversized, stale, timeout, restamp, short chunk
		queue_word(valid_reply(1'b0, ksc_pkg::FULL_CHUNK_LEN));
		queue_word(valid_reply(1'b0, 8'hFF));
		queue_word(mk(ksc_pkg::FUNC_REPLY, 1'b0, 6'd0, ksc_pkg::FULL_CHUNK_LEN));
		queue_word(mk(ksc_pkg::FUNC_TIMEOUT, 1'b0, 6'd0, 8'd0));
		queue_word(valid_reply(1'b1, 8'd0));
		queue_word(valid_reply(1'b0, 8'd0));
		wait_drained();
		write_reg(ksc_pkg::REG_FILE_COUNT, 8'd255);
		queue_word(valid_reply(1'b0, 8'd0));
		queue_word(mk(ksc_pkg::func_t'(FUNC_UNUSED), 1'b0, 6'd0, 8'd0));
		queue_word(valid_reply(1'b0, 8'd0));
		queue_word(valid_reply(1'b0, ksc_pkg::FULL_CHUNK_LEN - 8'd1));
		queue_word(valid_reply(1'b0, 8'd0));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			write_reg(ksc_pkg::REG_FILE_COUNT,
			          (p == 0 || files_sent > 8'd170) ? 8'd255 :
			          8'(files_sent + $urandom_range(60, 85)));
			write_reg(ksc_pkg::REG_INIT_RETRIES, {5'($urandom),
			          (p == 0) ? 3'd0 : (p == 1) ? 3'd1 : 3'($urandom_range(0, 7))});
			write_reg(ksc_pkg::REG_RETRY_LIMIT, {5'($urandom),
			          (p == 0) ? 3'd7 : (p == 1) ? 3'd1 : 3'($urandom_range(1, 7))});
			n = 0;
			while (n < PHASE_WORDS) begin
				queue_random_step(c);
				n += c;
			end
		end

		wait_drained();
		pick = $urandom_range(0, 2);
		if (ph == PH_STOP || ph == PH_ABORT) begin
			how_ended = "finished early";
		end else if (pick == 2) begin
			// budget register of zero still allows one try
			how_ended = "aborted";
			write_reg(ksc_pkg::REG_RETRY_LIMIT, {5'($urandom), 3'd0});
			queue_word(valid_reply(1'b1, 8'($urandom)));
			queue_word(mk(ksc_pkg::FUNC_TIMEOUT, 1'b0, 6'($urandom), 8'($urandom)));
		end else if (pick == 1 && ph != PH_EOT && files_sent < cfg_files) begin
			how_ended = "done, no file left for F";
			while (ph != PH_FILE)
				queue_word(valid_reply(1'b0,
				                       8'($urandom_range(0, ksc_pkg::FULL_CHUNK - 1))));
			wait_drained();
			write_reg(ksc_pkg::REG_FILE_COUNT, 8'd1);
			queue_word(valid_reply(1'b1, 8'($urandom)));
			queue_word(valid_reply(1'b0, 8'($urandom)));
			queue_word(valid_reply(1'b0, 8'($urandom)));
		end else begin
			how_ended = "done after last file";
			write_reg(ksc_pkg::REG_FILE_COUNT, (files_sent == 8'd0) ? 8'd1 : files_sent);
			while (ph != PH_STOP)
				queue_word(valid_reply($urandom_range(0, 5) == 0,
				                       8'($urandom_range(0, ksc_pkg::FULL_CHUNK - 1))));
		end
		// everything after the end is ignored
		repeat (12)
			queue_word(mk(ksc_pkg::func_t'($urandom_range(0, 3)), 1'($urandom),
			              6'($urandom), 8'($urandom)));
		wait_drained();
		repeat (4) @(negedge clk);

		$display("Covered %0d event words, %0d packets checked, %0d files, session %s",
		         events_sent, packets_checked, files_sent, how_ended);
		$display("Planned S %0d F %0d D %0d Z %0d B %0d resend %0d restamp %0d none %0d",
		         actions_planned[ksc_pkg::ACT_S], actions_planned[ksc_pkg::ACT_F],
		         actions_planned[ksc_pkg::ACT_D], actions_planned[ksc_pkg::ACT_Z],
		         actions_planned[ksc_pkg::ACT_B], actions_planned[ksc_pkg::ACT_RESEND],
		         actions_planned[ksc_pkg::ACT_RESTAMP], actions_planned[ksc_pkg::ACT_NONE]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
